// File: hw/rtl/mse_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mse_pkg
// Shared types and constants for the merge sort engine.
// ----------------------------------------------------------------------------
package mse_pkg;

  localparam int unsigned DATA_W = 32;

  // input transfer payload
  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     is_last;
  } in_t;

  // result transfer payload
  typedef struct packed {
    logic signed [DATA_W-1:0] sorted_value;
    logic                     end_of_run;
    logic                     overflow;
  } out_t;

  // sequencer states, one-hot
  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_SETUP = 6'b000010,
    ST_READ  = 6'b000100,
    ST_CMP   = 6'b001000,
    ST_EMIT  = 6'b010000,
    ST_DONE  = 6'b100000
  } state_e;

endpackage

// File: hw/rtl/merge_sort_engine_unit.sv
`timescale 1ns / 1ps
// Loading takes one value per cycle; values are taken while busy is low.
// The sort is a bottom-up merge over two ping-pong buffers and one shared
// comparator, in ceil(log2 N) passes; each pair of runs gets a setup step,
// then each element a read and a compare step, and then N results follow.
// The receiver cannot stall; every result shows for one cycle on out_valid_o.
// Reset clears the count, overflow flag and sequencer; buffers are not cleared.
// ----------------------------------------------------------------------------
// merge_sort_engine_unit
// Collects signed values, sorts them ascending by iterative merge, emits run.
// ----------------------------------------------------------------------------
module merge_sort_engine_unit import mse_pkg::*; #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  in_t  in_i,
  output logic out_valid_o,
  output out_t out_o
);

  localparam int unsigned AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);
  localparam int unsigned SW = CW + 2;

  state_e        state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic          dropped_q, dropped_d;
  logic          sel_q, sel_d;       // 0: buffer a is the source
  logic [SW-1:0] width_q, width_d;
  logic [CW-1:0] base_q, base_d;
  logic [CW-1:0] i_q, i_d, iend_q, iend_d;
  logic [CW-1:0] j_q, j_d, jend_q, jend_d;
  logic [CW-1:0] k_q, k_d;
  logic [CW-1:0] e_q, e_d;
  logic          out_vld_q, out_vld_d;
  logic          out_last_q, out_last_d;
  logic          out_ovf_q, out_ovf_d;

  logic                     accept;
  logic                     room;
  logic [AW-1:0]            raddr_a, raddr_b;
  logic [DATA_W-1:0]        rd_aa, rd_ab, rd_ba, rd_bb;
  logic signed [DATA_W-1:0] left_v, right_v;
  logic                     take_right;
  logic [DATA_W-1:0]        merge_v;
  logic                     we_a, we_b;
  logic [AW-1:0]            waddr_a, waddr_b;
  logic [DATA_W-1:0]        wdata_a;
  logic [SW-1:0]            sum_w, sum_2w, width_x2;

  assign accept = start && !busy;
  assign busy   = (state_q != ST_IDLE);
  assign room   = (count_q < CW'(MAX_ITEMS));

  // run bounds for the pair of runs starting at base
  assign sum_w    = SW'(base_q) + width_q;
  assign sum_2w   = SW'(base_q) + (width_q << 1);
  assign width_x2 = width_q << 1;

  // shared comparator on the source buffer's read data
  assign left_v     = sel_q ? rd_ba : rd_aa;
  assign right_v    = sel_q ? rd_bb : rd_ab;
  assign take_right = (i_q == iend_q) || ((j_q != jend_q) && (right_v < left_v));
  assign merge_v    = take_right ? right_v : left_v;

  // read address selection
  always_comb begin
    raddr_a = i_q[AW-1:0];
    raddr_b = j_q[AW-1:0];
    if (state_q == ST_EMIT) begin
      raddr_a = e_q[AW-1:0];
    end
  end

  // buffer write ports: loading goes to a, merges go to the destination
  always_comb begin
    we_a    = 1'b0;
    waddr_a = k_q[AW-1:0];
    wdata_a = merge_v;
    if (state_q == ST_IDLE) begin
      we_a    = accept && room;
      waddr_a = count_q[AW-1:0];
      wdata_a = in_i.value;
    end else if (state_q == ST_CMP) begin
      we_a = sel_q;
    end
  end

  assign we_b    = (state_q == ST_CMP) && !sel_q;
  assign waddr_b = k_q[AW-1:0];

  mse_ram #(
    .DEPTH (MAX_ITEMS),
    .WIDTH (DATA_W),
    .AW    (AW)
  ) u_ram_a (
    .clk_i     (clk_i),
    .we_i      (we_a),
    .waddr_i   (waddr_a),
    .wdata_i   (wdata_a),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rd_aa),
    .rdata_b_o (rd_ab)
  );

  mse_ram #(
    .DEPTH (MAX_ITEMS),
    .WIDTH (DATA_W),
    .AW    (AW)
  ) u_ram_b (
    .clk_i     (clk_i),
    .we_i      (we_b),
    .waddr_i   (waddr_b),
    .wdata_i   (merge_v),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rd_ba),
    .rdata_b_o (rd_bb)
  );

  // sequencer
  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    dropped_d  = dropped_q;
    sel_d      = sel_q;
    width_d    = width_q;
    base_d     = base_q;
    i_d        = i_q;
    iend_d     = iend_q;
    j_d        = j_q;
    jend_d     = jend_q;
    k_d        = k_q;
    e_d        = e_q;
    out_vld_d  = 1'b0;
    out_last_d = 1'b0;
    out_ovf_d  = out_ovf_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (room) begin
            count_d = count_q + CW'(1);
          end else begin
            dropped_d = 1'b1;
          end
          if (in_i.is_last) begin
            sel_d   = 1'b0;
            width_d = SW'(1);
            base_d  = '0;
            e_d     = '0;
            if (count_d <= CW'(1)) begin
              state_d = ST_EMIT;
            end else begin
              state_d = ST_SETUP;
            end
          end
        end
      end
      ST_SETUP: begin
        i_d     = base_q;
        k_d     = base_q;
        iend_d  = (sum_w < SW'(count_q)) ? sum_w[CW-1:0] : count_q;
        j_d     = iend_d;
        jend_d  = (sum_2w < SW'(count_q)) ? sum_2w[CW-1:0] : count_q;
        state_d = ST_READ;
      end
      ST_READ: begin
        state_d = ST_CMP;
      end
      ST_CMP: begin
        k_d = k_q + CW'(1);
        if (take_right) begin
          j_d = j_q + CW'(1);
        end else begin
          i_d = i_q + CW'(1);
        end
        if (k_d == jend_q) begin
          // pair of runs merged
          base_d = jend_q;
          if (jend_q >= count_q) begin
            sel_d   = !sel_q;
            width_d = width_x2;
            base_d  = '0;
            if (width_x2 >= SW'(count_q)) begin
              e_d     = '0;
              state_d = ST_EMIT;
            end else begin
              state_d = ST_SETUP;
            end
          end else begin
            state_d = ST_SETUP;
          end
        end else begin
          state_d = ST_READ;
        end
      end
      ST_EMIT: begin
        out_vld_d  = 1'b1;
        out_last_d = (e_q == count_q - CW'(1));
        out_ovf_d  = dropped_q;
        e_d        = e_q + CW'(1);
        if (out_last_d) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        count_d   = '0;
        dropped_d = 1'b0;
        state_d   = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      count_q    <= '0;
      dropped_q  <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      dropped_q  <= dropped_d;
      out_vld_q  <= out_vld_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    sel_q      <= sel_d;
    width_q    <= width_d;
    base_q     <= base_d;
    i_q        <= i_d;
    iend_q     <= iend_d;
    j_q        <= j_d;
    jend_q     <= jend_d;
    k_q        <= k_d;
    e_q        <= e_d;
    out_last_q <= out_last_d;
    out_ovf_q  <= out_ovf_d;
  end

  // result transfer: registered read data of the source buffer, valid in the cycle after issue
  assign out_valid_o        = out_vld_q;
  assign out_o.sorted_value = sel_q ? rd_ba : rd_aa;
  assign out_o.end_of_run   = out_last_q;
  assign out_o.overflow     = out_ovf_q;

endmodule

// File: hw/rtl/mse_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mse_ram
// Element buffer: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module mse_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 32,
  parameter int unsigned AW    = 6
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_a_i,
  input  logic [AW-1:0]    raddr_b_i,
  output logic [WIDTH-1:0] rdata_a_o,
  output logic [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // two registered read ports
  always_ff @(posedge clk_i) begin
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// File: tb/merge_sort_engine_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// merge_sort_engine_unit_tb
// Drives sets of signed values into the sort engine, with random idling, and
// checks every result against an insertion-sort predictor or a row's want.
// ----------------------------------------------------------------------------
module merge_sort_engine_unit_tb import mse_pkg::*; ();

  localparam int unsigned MAX_ITEMS    = 64;
  localparam int unsigned IDLE_PCT     = 36;
  localparam int unsigned RAND_ITEMS   = 180;
  localparam int unsigned DRAIN_CYCLES = 200;
  localparam int unsigned TIMEOUT_NS   = 400_000;
  localparam int unsigned NUM_ROWS     = 13;

  localparam logic signed [DATA_W-1:0] MIN_V = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] MAX_V = 32'sh7fff_ffff;

  // how the leading values of a directed set are formed
  typedef enum logic [1:0] {
    FILL_SAME,
    FILL_RAND,
    FILL_DESC,
    FILL_ASC
  } fill_e;

  typedef struct packed {
    logic [7:0]               len;
    logic signed [DATA_W-1:0] val;
    fill_e                    fill;
    logic                     typed;
    out_t                     want;
  } set_row_t;

  // directed sets: val is the final value of each set
  localparam set_row_t SET_TABLE [NUM_ROWS] = '{
    '{8'd1,  MIN_V,          FILL_SAME, 1'b1, '{MIN_V, 1'b1, 1'b0}},
    '{8'd1,  MAX_V,          FILL_SAME, 1'b1, '{MAX_V, 1'b1, 1'b0}},
    '{8'd1,  32'sd0,         FILL_SAME, 1'b1, '{32'sd0, 1'b1, 1'b0}},
    '{8'd1,  -32'sd1,        FILL_SAME, 1'b1, '{-32'sd1, 1'b1, 1'b0}},
    '{8'd2,  MIN_V,          FILL_DESC, 1'b0, '0},
    '{8'd5,  32'sd0,         FILL_RAND, 1'b0, '0},
    '{8'd4,  32'sd7,         FILL_SAME, 1'b0, '0},
    '{8'd6,  MAX_V,          FILL_ASC,  1'b0, '0},
    '{8'd3,  32'sh5555_5555, FILL_RAND, 1'b0, '0},
    '{8'd64, -32'sd5,        FILL_DESC, 1'b0, '0},
    '{8'd65, 32'sd123,       FILL_RAND, 1'b0, '0},
    '{8'd67, MIN_V,          FILL_RAND, 1'b0, '0},
    '{8'd2,  32'shaaaa_aaaa, FILL_SAME, 1'b0, '0}
  };

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_t  in_i = '0;
  logic out_valid_o;
  out_t out_o;

  // predictor state
  logic signed [DATA_W-1:0] held_vals [MAX_ITEMS];
  int unsigned              held_count = 0;
  logic                     dropped = 1'b0;
  out_t                     sorted_q [$];

  // side information travelling with the driven item
  logic        row_typed = 1'b0;
  out_t        row_want = '0;
  logic        calm = 1'b0;
  int unsigned mismatches = 0;
  int unsigned items_sent = 0;
  out_t        oldest;

  merge_sort_engine_unit #(
    .MAX_ITEMS(MAX_ITEMS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .out_o      (out_o)
  );

  always #1 clk_i = ~clk_i;

  task automatic note_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // store or drop one value; on the final one queue the sorted run
  function automatic void absorb_value(input in_t item, input logic typed, input out_t want);
    logic signed [DATA_W-1:0] ordered [MAX_ITEMS];
    logic signed [DATA_W-1:0] key;
    int unsigned              n;
    int unsigned              i;
    int unsigned              j;
    out_t                     res;
    if (held_count < MAX_ITEMS) begin
      held_vals[held_count] = item.value;
      held_count++;
    end else begin
      dropped = 1'b1;
    end
    if (!item.is_last) return;
    n = held_count;
    for (i = 0; i < n; i++) ordered[i] = held_vals[i];
    for (i = 1; i < n; i++) begin
      key = ordered[i];
      j = i;
      while (j > 0 && key < ordered[j-1]) begin
        ordered[j] = ordered[j-1];
        j--;
      end
      ordered[j] = key;
    end
    if (typed) begin
      sorted_q.push_back(want);
    end else begin
      for (i = 0; i < n; i++) begin
        res.sorted_value = ordered[i];
        res.end_of_run   = (i == n - 1);
        res.overflow     = dropped;
        sorted_q.push_back(res);
      end
    end
    held_count = 0;
    dropped    = 1'b0;
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(9)) inside
      [0:4]:   pick_value = $urandom;
      [5:6]:   pick_value = int'($urandom_range(8)) - 4;
      7:       pick_value = MIN_V + $urandom_range(3);
      8:       pick_value = MAX_V - $urandom_range(3);
      default: pick_value = $urandom & 32'h0000_ffff;
    endcase
  endfunction

  // one input transfer, with random idle cycles ahead of it unless calm is set
  task automatic send_item(input in_t item, input logic typed, input out_t want);
    if (!calm) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        start = 1'b0;
        @(negedge clk_i);
      end
    end
    start     = 1'b1;
    in_i      = item;
    row_typed = typed;
    row_want  = want;
    do @(posedge clk_i); while (busy);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    start = 1'b0;
    while (sorted_q.size() != 0) @(negedge clk_i);
  endtask

  // result check first, then prediction of the transfer taken at this edge
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o) begin
      if (sorted_q.size() == 0) begin
        note_mismatch($sformatf("unexpected result %0d", out_o.sorted_value));
      end else begin
        oldest = sorted_q.pop_front();
        if (out_o.sorted_value !== oldest.sorted_value)
          note_mismatch($sformatf("sorted_value %0d, want %0d",
                                  out_o.sorted_value, oldest.sorted_value));
        if (out_o.end_of_run !== oldest.end_of_run)
          note_mismatch($sformatf("end_of_run %b, want %b",
                                  out_o.end_of_run, oldest.end_of_run));
        if (out_o.overflow !== oldest.overflow)
          note_mismatch($sformatf("overflow %b, want %b",
                                  out_o.overflow, oldest.overflow));
      end
    end
    if (rst_ni && start && !busy) absorb_value(in_i, row_typed, row_want);
  end

  // watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    set_row_t    row;
    in_t         item;
    int unsigned r;
    int unsigned k;
    int unsigned len;
    int unsigned set_idx;
    int unsigned rand_sent;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed sets
    for (r = 0; r < NUM_ROWS; r++) begin
      row = SET_TABLE[r];
      for (k = 0; k < row.len; k++) begin
        item.is_last = (k == row.len - 1);
        case (row.fill)
          FILL_SAME: item.value = row.val;
          FILL_DESC: item.value = row.val + (int'(row.len) - 1 - int'(k));
          FILL_ASC:  item.value = row.val - (int'(row.len) - 1 - int'(k));
          default:   item.value = item.is_last ? row.val : pick_value();
        endcase
        send_item(item, row.typed && item.is_last, row.want);
      end
    end

    // hold off until every run so far has come out
    wait_drained();

    // random sets, mostly short, now and then at or past capacity
    set_idx   = 0;
    rand_sent = 0;
    while (rand_sent < RAND_ITEMS) begin
      r = $urandom_range(99);
      if (r < 80)      len = $urandom_range(8, 1);
      else if (r < 90) len = $urandom_range(63, 9);
      else             len = $urandom_range(70, 64);
      calm = (set_idx >= 3 && set_idx < 9);
      if (set_idx == 9) wait_drained();
      for (k = 0; k < len; k++) begin
        item.value   = pick_value();
        item.is_last = (k == len - 1);
        send_item(item, 1'b0, '0);
        rand_sent++;
      end
      set_idx++;
    end
    start = 1'b0;

    // drain, then watch for stray results
    while (sorted_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: merge_sort_engine_unit.f
hw/rtl/mse_pkg.sv
hw/rtl/mse_ram.sv
hw/rtl/merge_sort_engine_unit.sv
tb/merge_sort_engine_unit_tb.sv
